FILE: design/dapt_pkg.sv
// dapt_pkg: shared types, codes and constants for the dual-axis pid position tracker
// used by every module in the design folder; depends on nothing else

package dapt_pkg;

    // fixed field widths
    localparam int POS_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 16;
    localparam int DECIM_W  = 8;
    localparam int EFFORT_W = 12;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    // defaults for the top-level parameters
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int EFFORT_LIMIT_DEF   = 1800;

    // request type codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_MODE   = 2'd1;
    localparam logic [1:0] REQ_TARGET = 2'd2;

    // mode codes as seen on the ports
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_HOLD  = 2'd1;
    localparam logic [1:0] MODE_TRACK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LEN   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DECIM = 3'd4;

    // reset values of the configuration registers
    localparam logic signed [GAIN_W-1:0] KP_RESET    = 16'sd512;
    localparam logic [DECIM_W-1:0]       DECIM_RESET = 8'd1;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [POS_W-1:0] actual_pos_a;
        logic signed [POS_W-1:0] actual_pos_b;
        logic signed [POS_W-1:0] ref_pos_a;
        logic signed [POS_W-1:0] ref_pos_b;
        logic [1:0]              new_mode;
        logic                    target_motor;
        logic signed [POS_W-1:0] target_angle;
    } req_t;

    typedef struct packed {
        logic                       effort_valid;
        logic signed [EFFORT_W-1:0] effort_a;
        logic signed [EFFORT_W-1:0] effort_b;
        logic                       log_strobe;
        logic [1:0]                 mode_now;
    } res_t;

    // per-request side information that travels beside the lane datapath
    typedef struct packed {
        logic       pid;
        logic       strobe;
        logic [1:0] mode;
    } tag_t;

    // stage controls handed from the sequencer to each lane
    typedef struct packed {
        logic load;
        logic upd;
        logic adv2;
        logic adv3;
        logic adv4;
        logic clr;
    } lane_ctl_t;

endpackage

FILE: design/dapt_lane.sv
// dapt_lane: one motor's pid datapath, error state plus a four-stage pipeline
// depends on dapt_pkg

module dapt_lane #(
    parameter int GAIN_FRAC_BITS = dapt_pkg::GAIN_FRAC_BITS_DEF,
    parameter int EFFORT_LIMIT   = dapt_pkg::EFFORT_LIMIT_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  dapt_pkg::lane_ctl_t                      ctl,
    input  logic signed [dapt_pkg::POS_W-1:0]        target,
    input  logic signed [dapt_pkg::POS_W-1:0]        actual,
    input  logic signed [dapt_pkg::GAIN_W-1:0]       kp,
    input  logic signed [dapt_pkg::GAIN_W-1:0]       ki,
    input  logic signed [dapt_pkg::GAIN_W-1:0]       kd,
    output logic signed [dapt_pkg::EFFORT_W-1:0]     effort
);
    import dapt_pkg::*;

    localparam int DIFF_W = POS_W + 1;
    localparam int PP_W   = GAIN_W + POS_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int SUM_W  = PD_W + 2;
    localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(EFFORT_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;

    logic signed [DIFF_W-1:0] diff_e;
    logic signed [DIFF_W-1:0] diff_i;
    logic signed [POS_W-1:0]  e_next;
    logic signed [POS_W-1:0]  ei_next;
    logic signed [DIFF_W-1:0] ed_next;

    logic signed [POS_W-1:0]  e_reg;
    logic signed [POS_W-1:0]  ei_reg;
    logic signed [DIFF_W-1:0] ed_reg;
    logic signed [POS_W-1:0]  prev_reg;
    logic signed [POS_W-1:0]  integ_reg;

    // the error value that belongs to the item now in stage 2
    logic signed [POS_W-1:0]  e2_reg;

    logic signed [PP_W-1:0]   pkp_reg;
    logic signed [PP_W-1:0]   pki_reg;
    logic signed [PD_W-1:0]   pkd_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  clamped;

    // stage 1: saturated error against the target
    assign diff_e = DIFF_W'(target) - DIFF_W'(actual);
    assign e_next = (diff_e[DIFF_W-1] ^ diff_e[DIFF_W-2])
                  ? {diff_e[DIFF_W-1], {(POS_W-1){~diff_e[DIFF_W-1]}}}
                  : diff_e[POS_W-1:0];

    // stage 2: integral and difference against stored state
    assign diff_i  = DIFF_W'(integ_reg) + DIFF_W'(e_reg);
    assign ei_next = (diff_i[DIFF_W-1] ^ diff_i[DIFF_W-2])
                   ? {diff_i[DIFF_W-1], {(POS_W-1){~diff_i[DIFF_W-1]}}}
                   : diff_i[POS_W-1:0];
    assign ed_next = DIFF_W'(e_reg) - DIFF_W'(prev_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else if (ctl.clr)
        begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else if (ctl.upd)
        begin
            prev_reg  <= e_reg;
            integ_reg <= ei_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            e_reg <= e_next;
        end
        if (ctl.adv2)
        begin
            e2_reg <= e_reg;
            ei_reg <= ei_next;
            ed_reg <= ed_next;
        end
        // stage 3: one multiplier per gain
        if (ctl.adv3)
        begin
            pkp_reg <= PP_W'(kp) * PP_W'(e2_reg);
            pki_reg <= PP_W'(ki) * PP_W'(ei_reg);
            pkd_reg <= PD_W'(kd) * PD_W'(ed_reg);
        end
        // stage 4: sum of the three terms
        if (ctl.adv4)
        begin
            sum_reg <= SUM_W'(pkp_reg) + SUM_W'(pki_reg) + SUM_W'(pkd_reg);
        end
    end

    // floor division by the gain scale, then clamp
    assign shifted = sum_reg >>> GAIN_FRAC_BITS;

    always_comb
    begin
        priority if (shifted > LIM_POS)
        begin
            clamped = LIM_POS;
        end
        else if (shifted < LIM_NEG)
        begin
            clamped = LIM_NEG;
        end
        else
        begin
            clamped = shifted;
        end
    end

    assign effort = clamped[EFFORT_W-1:0];

endmodule

FILE: design/dapt_merge.sv
// dapt_merge: joins both lane efforts and the request tag into the result register
// depends on dapt_pkg

module dapt_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 stage_valid,
    output logic                                 stage_ready,
    input  dapt_pkg::tag_t                       tag,
    input  logic signed [dapt_pkg::EFFORT_W-1:0] effort_a,
    input  logic signed [dapt_pkg::EFFORT_W-1:0] effort_b,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output dapt_pkg::res_t                       res_data
);
    import dapt_pkg::*;

    logic valid_reg;
    res_t res_reg;
    res_t res_next;

    assign stage_ready = !valid_reg || res_ready;

    always_comb
    begin
        res_next.effort_valid = tag.pid;
        res_next.effort_a     = tag.pid ? effort_a : '0;
        res_next.effort_b     = tag.pid ? effort_b : '0;
        res_next.log_strobe   = tag.strobe;
        res_next.mode_now     = tag.mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && stage_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = res_reg;

endmodule

FILE: design/dual_axis_pid_position_tracker_unit.sv
// dual_axis_pid_position_tracker_unit: top level, request sequencing, mode and trajectory state
// depends on dapt_pkg, dapt_lane and dapt_merge

// Two-motor pid position controller. Each request (control tick, set mode or
// set target) gives exactly one result, in order. One request is taken per
// clock cycle sustained while results are taken. The steps to a result are:
// the error is captured at the edge that takes the request, then come
// integral/difference, the gain multipliers and the three-term sum in each
// motor lane, then the result register. Mode, trajectory index, decimation
// count and targets change at the moment a request is taken, so back-to-back
// requests see each other.
// The two motor lanes run side by side, one multiplier per gain each, and
// the merge stage joins their efforts with the mode and log strobe. When the
// result register is held by res_ready low the pipeline stalls behind it.
// Configuration writes go through cfg_we/cfg_addr/cfg_wdata with no wait and
// are expected only while no request is in flight; a gain write clears both
// lanes' error history.

module dual_axis_pid_position_tracker_unit #(
    parameter int GAIN_FRAC_BITS = dapt_pkg::GAIN_FRAC_BITS_DEF,
    parameter int EFFORT_LIMIT   = dapt_pkg::EFFORT_LIMIT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  dapt_pkg::req_t                req_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dapt_pkg::res_t                res_data,
    input  logic                          cfg_we,
    input  logic [dapt_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [dapt_pkg::CFG_DW-1:0]   cfg_wdata
);
    import dapt_pkg::*;

    // one-hot operating mode
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_HOLD  = 3'b010,
        ST_TRACK = 3'b100
    } mode_t;

    // configuration registers
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [DECIM_W-1:0]       decim_cfg_reg;

    // controller state
    mode_t                   mode_reg;
    mode_t                   mode_next;
    logic [LEN_W-1:0]        idx_reg;
    logic [LEN_W-1:0]        idx_next;
    logic [DECIM_W-1:0]      decim_reg;
    logic [DECIM_W-1:0]      decim_next;
    logic [DECIM_W-1:0]      decim_inc;
    logic signed [POS_W-1:0] tgt_a_reg;
    logic signed [POS_W-1:0] tgt_a_next;
    logic signed [POS_W-1:0] tgt_b_reg;
    logic signed [POS_W-1:0] tgt_b_next;

    // pipeline control
    logic accept;
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    tag_t tag_next;
    tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic merge_ready;
    logic gain_clr;
    lane_ctl_t lane_ctl;

    // lane inputs and outputs
    logic signed [POS_W-1:0]    lane_tgt_a;
    logic signed [POS_W-1:0]    lane_tgt_b;
    logic signed [EFFORT_W-1:0] effort_a;
    logic signed [EFFORT_W-1:0] effort_b;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= KP_RESET;
            ki_reg        <= '0;
            kd_reg        <= '0;
            len_reg       <= '0;
            decim_cfg_reg <= DECIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_KP:    kp_reg        <= cfg_wdata;
                CFG_KI:    ki_reg        <= cfg_wdata;
                CFG_KD:    kd_reg        <= cfg_wdata;
                CFG_LEN:   len_reg       <= cfg_wdata;
                CFG_DECIM: decim_cfg_reg <= cfg_wdata[DECIM_W-1:0];
                default:   ;
            endcase
        end
    end

    // any gain write wipes the error history of both lanes
    assign gain_clr = cfg_we && (cfg_addr == CFG_KP || cfg_addr == CFG_KI
                                 || cfg_addr == CFG_KD);

    // ---------------------------------------------------------------
    // request decode: next state and the tag for this request
    // ---------------------------------------------------------------
    assign decim_inc = decim_reg + 8'd1;

    always_comb
    begin
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        decim_next      = decim_reg;
        tgt_a_next      = tgt_a_reg;
        tgt_b_next      = tgt_b_reg;
        lane_tgt_a      = tgt_a_reg;
        lane_tgt_b      = tgt_b_reg;
        tag_next.pid    = 1'b0;
        tag_next.strobe = 1'b0;

        unique case (req_data.req_type)
            REQ_TICK:
            begin
                unique case (mode_reg)
                    ST_HOLD:
                    begin
                        tag_next.pid = 1'b1;
                    end
                    ST_TRACK:
                    begin
                        if (idx_reg >= len_reg)
                        begin
                            // trajectory done: rewind and hold, no effort this tick
                            idx_next  = '0;
                            mode_next = ST_HOLD;
                        end
                        else
                        begin
                            tgt_a_next   = req_data.ref_pos_a;
                            tgt_b_next   = req_data.ref_pos_b;
                            lane_tgt_a   = req_data.ref_pos_a;
                            lane_tgt_b   = req_data.ref_pos_b;
                            tag_next.pid = 1'b1;
                            idx_next     = idx_reg + 16'd1;
                            // a decimation setting of zero strobes every tick
                            if (decim_inc >= decim_cfg_reg)
                            begin
                                tag_next.strobe = 1'b1;
                                decim_next      = '0;
                            end
                            else
                            begin
                                decim_next = decim_inc;
                            end
                        end
                    end
                    default:
                    begin
                        // idle: nothing to compute
                    end
                endcase
            end
            REQ_MODE:
            begin
                // the unused mode code leaves the mode alone
                unique case (req_data.new_mode)
                    MODE_IDLE:  mode_next = ST_IDLE;
                    MODE_HOLD:  mode_next = ST_HOLD;
                    MODE_TRACK: mode_next = ST_TRACK;
                    default:    ;
                endcase
            end
            REQ_TARGET:
            begin
                if (req_data.target_motor)
                begin
                    tgt_b_next = req_data.target_angle;
                end
                else
                begin
                    tgt_a_next = req_data.target_angle;
                end
            end
            default:
            begin
                // unused request type: result carries the mode only
            end
        endcase

        unique case (mode_next)
            ST_HOLD:  tag_next.mode = MODE_HOLD;
            ST_TRACK: tag_next.mode = MODE_TRACK;
            default:  tag_next.mode = MODE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ST_IDLE;
            idx_reg   <= '0;
            decim_reg <= '0;
            tgt_a_reg <= '0;
            tgt_b_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            decim_reg <= decim_next;
            tgt_a_reg <= tgt_a_next;
            tgt_b_reg <= tgt_b_next;
        end
    end

    // ---------------------------------------------------------------
    // pipeline valids: each stage moves when the one after it has room
    // ---------------------------------------------------------------
    assign en4       = !v4_reg || merge_ready;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req_ready = en1;
    assign accept    = req_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= accept;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // tags ride alongside the lane data
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            tag1_reg <= tag_next;
        end
        if (en2)
        begin
            tag2_reg <= tag1_reg;
        end
        if (en3)
        begin
            tag3_reg <= tag2_reg;
        end
        if (en4)
        begin
            tag4_reg <= tag3_reg;
        end
    end

    // lane stage controls; error state only moves for requests that run the pid
    always_comb
    begin
        lane_ctl.load = en1;
        lane_ctl.upd  = v1_reg && en2 && tag1_reg.pid;
        lane_ctl.adv2 = en2;
        lane_ctl.adv3 = en3;
        lane_ctl.adv4 = en4;
        lane_ctl.clr  = gain_clr;
    end

    // ---------------------------------------------------------------
    // motor lanes and merge
    // ---------------------------------------------------------------
    dapt_lane #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .EFFORT_LIMIT   (EFFORT_LIMIT)
    ) u_lane_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .target (lane_tgt_a),
        .actual (req_data.actual_pos_a),
        .kp     (kp_reg),
        .ki     (ki_reg),
        .kd     (kd_reg),
        .effort (effort_a)
    );

    dapt_lane #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .EFFORT_LIMIT   (EFFORT_LIMIT)
    ) u_lane_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .target (lane_tgt_b),
        .actual (req_data.actual_pos_b),
        .kp     (kp_reg),
        .ki     (ki_reg),
        .kd     (kd_reg),
        .effort (effort_b)
    );

    dapt_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (v4_reg),
        .stage_ready (merge_ready),
        .tag         (tag4_reg),
        .effort_a    (effort_a),
        .effort_b    (effort_b),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

endmodule

FILE: design/dapt_checker.sv
// dapt_checker: port-level checks on the result channel, bound to the top level
// depends on dapt_pkg and dual_axis_pid_position_tracker_unit

module dapt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input dapt_pkg::res_t res_data
);
    import dapt_pkg::*;

    localparam int LIM = EFFORT_LIMIT_DEF;

    // a result with no effort carries zero drive on both motors
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.effort_valid |->
            res_data.effort_a == '0 && res_data.effort_b == '0)
        else $error("effort nonzero without effort_valid");

    // a log strobe only comes with a tracking tick that produced efforts
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.log_strobe |->
            res_data.effort_valid && res_data.mode_now == MODE_TRACK)
        else $error("log strobe outside a tracking effort");

    // efforts stay inside the clamp window
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.effort_valid |->
            int'(res_data.effort_a) <= LIM && int'(res_data.effort_a) >= -LIM
            && int'(res_data.effort_b) <= LIM && int'(res_data.effort_b) >= -LIM)
        else $error("effort beyond clamp limit");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

endmodule

bind dual_axis_pid_position_tracker_unit dapt_checker u_dapt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
